[sv/lqm_pkg.sv]
// shared constants, status codes and command types for the linked queue manager
package lqm_pkg;

  localparam int NUM_ELEMENTS = 32;
  localparam int NUM_QUEUES   = 4;

  localparam int ELEM_W  = $clog2(NUM_ELEMENTS);
  localparam int QUEUE_W = $clog2(NUM_QUEUES);
  localparam int CNT_W   = $clog2(NUM_ELEMENTS + 1);

  // operation codes
  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_QUEUED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_NOT_IN = 2'd3
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic issue;
    logic finish;
  } lqm_cmd_t;

endpackage

[sv/lqm_ctrl.sv]
// controller state machine: sequences the issue and finish steps of an operation and the result strobe
module lqm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              result_valid,
  output lqm_pkg::lqm_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_FINISH;
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // state and registered result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == S_FINISH);
    end
  end

  // commands to the datapath
  always_comb begin
    cmd.issue  = start && (state == S_IDLE);
    cmd.finish = (state == S_FINISH);
  end

  assign busy = (state == S_FINISH);

endmodule

[sv/lqm_dp.sv]
// datapath: link memories, owner tags, queue counts, head pointers and result registers
module lqm_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  lqm_pkg::lqm_cmd_t          cmd,
  input  logic                       action,
  input  logic [lqm_pkg::QUEUE_W-1:0] queue_id,
  input  logic [lqm_pkg::ELEM_W-1:0] element,
  output logic [1:0]                 status,
  output logic [lqm_pkg::CNT_W-1:0]  queue_length,
  output logic [lqm_pkg::ELEM_W-1:0] head_element,
  output logic                       head_present
);

  // per-element and per-queue bookkeeping
  logic [lqm_pkg::NUM_ELEMENTS-1:0] linked_flag;
  logic [lqm_pkg::QUEUE_W-1:0]      owner_queue  [lqm_pkg::NUM_ELEMENTS];
  logic [lqm_pkg::ELEM_W-1:0]       head_pointer [lqm_pkg::NUM_QUEUES];
  logic [lqm_pkg::CNT_W-1:0]        queue_count  [lqm_pkg::NUM_QUEUES];

  // ring link memories
  logic [lqm_pkg::ELEM_W-1:0] next_mem [lqm_pkg::NUM_ELEMENTS];
  logic [lqm_pkg::ELEM_W-1:0] prev_mem [lqm_pkg::NUM_ELEMENTS];
  logic [lqm_pkg::ELEM_W-1:0] next_rd;
  logic [lqm_pkg::ELEM_W-1:0] prev_rd;

  // operation held over the finish cycle
  logic                        act_r;
  logic [lqm_pkg::QUEUE_W-1:0] q_r;
  logic [lqm_pkg::ELEM_W-1:0]  e_r;
  lqm_pkg::status_t            st_r;
  logic                        nonempty_r;
  logic                        multi_r;

  // current state seen by the incoming beat
  logic [lqm_pkg::CNT_W-1:0]   cnt_cur;
  logic [lqm_pkg::ELEM_W-1:0]  head_cur;
  lqm_pkg::status_t            st_issue;
  logic                        ok_issue;

  // memory port controls
  logic                        next_we;
  logic [lqm_pkg::ELEM_W-1:0]  next_wa;
  logic [lqm_pkg::ELEM_W-1:0]  next_wd;
  logic                        prev_we;
  logic [lqm_pkg::ELEM_W-1:0]  prev_wa;
  logic [lqm_pkg::ELEM_W-1:0]  prev_wd;
  logic [lqm_pkg::ELEM_W-1:0]  prev_ra;

  // result values
  logic [lqm_pkg::CNT_W-1:0]   cnt_fin;
  logic [lqm_pkg::ELEM_W-1:0]  head_fin;
  logic                        head_moves;

  assign cnt_cur  = queue_count[queue_id];
  assign head_cur = head_pointer[queue_id];

  // status decision for the incoming beat
  always_comb begin
    if (action == lqm_pkg::ACT_APPEND) begin
      st_issue = linked_flag[element] ? lqm_pkg::ST_QUEUED : lqm_pkg::ST_OK;
    end else if (cnt_cur == '0) begin
      st_issue = lqm_pkg::ST_EMPTY;
    end else if (!linked_flag[element] || (owner_queue[element] != queue_id)) begin
      st_issue = lqm_pkg::ST_NOT_IN;
    end else begin
      st_issue = lqm_pkg::ST_OK;
    end
  end

  assign ok_issue = cmd.issue && (st_issue == lqm_pkg::ST_OK);

  // memory write selection: first half of an append at issue, relinking at finish
  always_comb begin
    next_we = 1'b0;
    next_wa = '0;
    next_wd = '0;
    prev_we = 1'b0;
    prev_wa = '0;
    prev_wd = '0;
    if (ok_issue && (action == lqm_pkg::ACT_APPEND)) begin
      next_we = 1'b1;
      next_wa = element;
      next_wd = (cnt_cur == '0) ? element : head_cur;
      prev_we = 1'b1;
      prev_wa = (cnt_cur == '0) ? element : head_cur;
      prev_wd = element;
    end else if (cmd.finish && (st_r == lqm_pkg::ST_OK)) begin
      if ((act_r == lqm_pkg::ACT_APPEND) && nonempty_r) begin
        next_we = 1'b1;
        next_wa = prev_rd;
        next_wd = e_r;
        prev_we = 1'b1;
        prev_wa = e_r;
        prev_wd = prev_rd;
      end else if ((act_r == lqm_pkg::ACT_REMOVE) && multi_r) begin
        next_we = 1'b1;
        next_wa = prev_rd;
        next_wd = next_rd;
        prev_we = 1'b1;
        prev_wa = next_rd;
        prev_wd = prev_rd;
      end
    end
  end

  // an append reads the old tail through the head, a remove reads its own links
  assign prev_ra = (action == lqm_pkg::ACT_APPEND) ? head_cur : element;

  // link memories, read-first with registered read data
  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (cmd.issue) begin
      next_rd <= next_mem[element];
      prev_rd <= prev_mem[prev_ra];
    end
  end

  // flags and counts, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      linked_flag <= '0;
      for (int i = 0; i < lqm_pkg::NUM_QUEUES; i++) begin
        queue_count[i] <= '0;
      end
    end else if (ok_issue) begin
      if (action == lqm_pkg::ACT_APPEND) begin
        linked_flag[element] <= 1'b1;
        queue_count[queue_id] <= cnt_cur + lqm_pkg::CNT_W'(1);
      end else begin
        linked_flag[element] <= 1'b0;
        queue_count[queue_id] <= cnt_cur - lqm_pkg::CNT_W'(1);
      end
    end
  end

  // head moves to the successor when the head itself is removed
  assign head_moves = (st_r == lqm_pkg::ST_OK) && (act_r == lqm_pkg::ACT_REMOVE) &&
                      multi_r && (head_pointer[q_r] == e_r);
  assign head_fin   = head_moves ? next_rd : head_pointer[q_r];
  assign cnt_fin    = queue_count[q_r];

  // owner tags, head pointers and the held operation
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      act_r      <= action;
      q_r        <= queue_id;
      e_r        <= element;
      st_r       <= st_issue;
      nonempty_r <= (cnt_cur != '0);
      multi_r    <= (cnt_cur > lqm_pkg::CNT_W'(1));
    end
    if (ok_issue && (action == lqm_pkg::ACT_APPEND)) begin
      owner_queue[element] <= queue_id;
      if (cnt_cur == '0) head_pointer[queue_id] <= element;
    end
    if (cmd.finish && head_moves) begin
      head_pointer[q_r] <= next_rd;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status       <= st_r;
      queue_length <= cnt_fin;
      head_present <= (cnt_fin != '0);
      head_element <= (cnt_fin != '0) ? head_fin : '0;
    end
  end

endmodule

[sv/linked_queue_manager_top.sv]
// top level of the linked queue manager: controller plus datapath
// an operation is taken on start while busy is low; busy is then high for one cycle
// no new operation is taken while busy is high, as the link memory read is followed by the relink write
// result_valid pulses for one cycle, registered from the finish state; the receiver cannot stall
// synchronous active-high rst clears the state machine, membership flags and queue counts
// link memories, owner tags and head pointers need no clearing and come out of reset unwritten
module linked_queue_manager_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       action,
  input  logic [lqm_pkg::QUEUE_W-1:0] queue_id,
  input  logic [lqm_pkg::ELEM_W-1:0] element,
  output logic                       result_valid,
  output logic [1:0]                 status,
  output logic [lqm_pkg::CNT_W-1:0]  queue_length,
  output logic [lqm_pkg::ELEM_W-1:0] head_element,
  output logic                       head_present
);

  lqm_pkg::lqm_cmd_t cmd;

  // sequencing
  lqm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .cmd          (cmd)
  );

  // storage and result formation
  lqm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .action       (action),
    .queue_id     (queue_id),
    .element      (element),
    .status       (status),
    .queue_length (queue_length),
    .head_element (head_element),
    .head_present (head_present)
  );

endmodule

[sv/lqm_checker.sv]
// port-level checker for the linked queue manager, bound to the top level
module lqm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       result_valid,
  input logic [1:0]                 status,
  input logic [lqm_pkg::CNT_W-1:0]  queue_length,
  input logic [lqm_pkg::ELEM_W-1:0] head_element,
  input logic                       head_present
);

  // every accepted beat must be followed by its result strobe
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 result_valid)
    else $error("result missing two cycles after accept");

  // a result only follows a busy cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(busy) && !busy))
    else $error("result without a preceding busy cycle");

  // head present exactly when the queue is non-empty
  a_present_len: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (head_present == (queue_length != '0)))
    else $error("head_present disagrees with queue_length");

  // an empty queue reports head zero
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !head_present) |-> (head_element == '0))
    else $error("empty queue reports a nonzero head");

  // a remove refused on an empty queue reports length zero
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status == lqm_pkg::ST_EMPTY)) |-> (queue_length == '0))
    else $error("empty status with nonzero length");

endmodule

bind linked_queue_manager_top lqm_checker u_lqm_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .status       (status),
  .queue_length (queue_length),
  .head_element (head_element),
  .head_present (head_present)
);

[tb/linked_queue_manager_top_test.sv]
// self-checking testbench for the linked queue manager top level
module linked_queue_manager_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // expected outcome of one queue operation
  typedef struct {
    lqm_pkg::status_t              status;
    logic [lqm_pkg::CNT_W-1:0]     length;
    logic [lqm_pkg::ELEM_W-1:0]    head;
    logic                          present;
  } op_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          action = lqm_pkg::ACT_APPEND;
  logic [lqm_pkg::QUEUE_W-1:0]   queue_id = '0;
  logic [lqm_pkg::ELEM_W-1:0]    element = '0;
  logic                          busy;
  logic                          result_valid;
  logic [1:0]                    status;
  logic [lqm_pkg::CNT_W-1:0]     queue_length;
  logic [lqm_pkg::ELEM_W-1:0]    head_element;
  logic                          head_present;

  // shadow copy of the ring links, membership and per-queue bookkeeping
  logic [lqm_pkg::ELEM_W-1:0]    nxt_link [lqm_pkg::NUM_ELEMENTS];
  logic [lqm_pkg::ELEM_W-1:0]    prv_link [lqm_pkg::NUM_ELEMENTS];
  bit                            in_queue [lqm_pkg::NUM_ELEMENTS];
  logic [lqm_pkg::QUEUE_W-1:0]   owner_of [lqm_pkg::NUM_ELEMENTS];
  logic [lqm_pkg::ELEM_W-1:0]    head_of  [lqm_pkg::NUM_QUEUES];
  int                            count_of [lqm_pkg::NUM_QUEUES];

  op_result_t                    pending_results [$];
  int                            mismatch_count = 0;
  bit                            idle_enable = 1'b1;

  linked_queue_manager_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .queue_id     (queue_id),
    .element      (element),
    .result_valid (result_valid),
    .status       (status),
    .queue_length (queue_length),
    .head_element (head_element),
    .head_present (head_present)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit, far above the slowest legal run
  initial begin
    #3_000_000;
    $display("linked_queue_manager_top_test failed");
    $finish;
  end

  // apply one append or remove to the shadow queues and return what the block must report
  function automatic op_result_t apply_queue_op(logic act, logic [lqm_pkg::QUEUE_W-1:0] q,
                                                logic [lqm_pkg::ELEM_W-1:0] e);
    op_result_t                  r;
    logic [lqm_pkg::ELEM_W-1:0]  first_e;
    logic [lqm_pkg::ELEM_W-1:0]  last_e;
    logic [lqm_pkg::ELEM_W-1:0]  nx;
    logic [lqm_pkg::ELEM_W-1:0]  pv;
    if (act == lqm_pkg::ACT_APPEND) begin
      if (in_queue[e]) begin
        r.status = lqm_pkg::ST_QUEUED;
      end else begin
        if (count_of[q] == 0) begin
          head_of[q] = e;
          nxt_link[e] = e;
          prv_link[e] = e;
        end else begin
          first_e = head_of[q];
          last_e = prv_link[first_e];
          nxt_link[last_e] = e;
          prv_link[first_e] = e;
          prv_link[e] = last_e;
          nxt_link[e] = first_e;
        end
        in_queue[e] = 1'b1;
        owner_of[e] = q;
        count_of[q]++;
        r.status = lqm_pkg::ST_OK;
      end
    end else if (count_of[q] == 0) begin
      // empty queue wins over membership
      r.status = lqm_pkg::ST_EMPTY;
    end else if (!in_queue[e] || owner_of[e] != q) begin
      r.status = lqm_pkg::ST_NOT_IN;
    end else begin
      if (count_of[q] != 1) begin
        nx = nxt_link[e];
        pv = prv_link[e];
        if (head_of[q] == e) head_of[q] = nx;
        nxt_link[pv] = nx;
        prv_link[nx] = pv;
      end
      in_queue[e] = 1'b0;
      count_of[q]--;
      r.status = lqm_pkg::ST_OK;
    end
    r.length = lqm_pkg::CNT_W'(count_of[q]);
    r.present = (count_of[q] != 0);
    r.head = r.present ? head_of[q] : '0;
    return r;
  endfunction

  // send one command beat, with an optional idle burst ahead of it
  task automatic send_op(logic act, logic [lqm_pkg::QUEUE_W-1:0] q,
                         logic [lqm_pkg::ELEM_W-1:0] e);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    queue_id <= q;
    element <= e;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(apply_queue_op(act, q, e));
  endtask

  // hold off until every outstanding result has come back
  task automatic wait_drained(int settle);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // result checker, one beat per strobe
  always @(posedge clk) begin : check_results
    op_result_t want;
    if (!rst && result_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no operation outstanding");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status expected %0d got %0d", want.status, status);
          mismatch_count++;
        end
        if (queue_length !== want.length) begin
          $error("queue_length expected %0d got %0d", want.length, queue_length);
          mismatch_count++;
        end
        if (head_element !== want.head) begin
          $error("head_element expected %0d got %0d", want.head, head_element);
          mismatch_count++;
        end
        if (head_present !== want.present) begin
          $error("head_present expected %0d got %0d", want.present, head_present);
          mismatch_count++;
        end
      end
    end
  end

  // every status code, head and tail and middle removal, cross-queue refusals
  task automatic test_directed();
    send_op(lqm_pkg::ACT_REMOVE, 2'd0, 5'd0);
    send_op(lqm_pkg::ACT_APPEND, 2'd0, 5'd5);
    send_op(lqm_pkg::ACT_APPEND, 2'd1, 5'd5);
    send_op(lqm_pkg::ACT_APPEND, 2'd0, 5'd5);
    send_op(lqm_pkg::ACT_REMOVE, 2'd1, 5'd5);
    send_op(lqm_pkg::ACT_REMOVE, 2'd0, 5'd9);
    send_op(lqm_pkg::ACT_APPEND, 2'd0, 5'd0);
    send_op(lqm_pkg::ACT_APPEND, 2'd0, 5'd31);
    send_op(lqm_pkg::ACT_APPEND, 2'd3, 5'd31);
    send_op(lqm_pkg::ACT_APPEND, 2'd2, 5'd7);
    send_op(lqm_pkg::ACT_REMOVE, 2'd2, 5'd31);
    send_op(lqm_pkg::ACT_REMOVE, 2'd0, 5'd0);
    send_op(lqm_pkg::ACT_APPEND, 2'd0, 5'd0);
    send_op(lqm_pkg::ACT_REMOVE, 2'd0, 5'd5);
    send_op(lqm_pkg::ACT_REMOVE, 2'd0, 5'd0);
    send_op(lqm_pkg::ACT_REMOVE, 2'd0, 5'd31);
    send_op(lqm_pkg::ACT_REMOVE, 2'd0, 5'd31);
    send_op(lqm_pkg::ACT_REMOVE, 2'd2, 5'd7);
    send_op(lqm_pkg::ACT_REMOVE, 2'd2, 5'd7);
    send_op(lqm_pkg::ACT_APPEND, 2'd3, 5'd31);
    send_op(lqm_pkg::ACT_APPEND, 2'd3, 5'd30);
    send_op(lqm_pkg::ACT_REMOVE, 2'd3, 5'd31);
    send_op(lqm_pkg::ACT_REMOVE, 2'd3, 5'd30);
    send_op(lqm_pkg::ACT_APPEND, 2'd1, 5'd16);
    send_op(lqm_pkg::ACT_REMOVE, 2'd1, 5'd16);
  endtask

  // empty everything, load the whole pool into one queue in random order, then unload it
  task automatic test_full_queue();
    int order [lqm_pkg::NUM_ELEMENTS];
    int j;
    int tmp;
    logic [lqm_pkg::QUEUE_W-1:0] q;
    for (int k = 0; k < lqm_pkg::NUM_ELEMENTS; k++) begin
      if (in_queue[k]) send_op(lqm_pkg::ACT_REMOVE, owner_of[k], lqm_pkg::ELEM_W'(k));
    end
    q = lqm_pkg::QUEUE_W'($urandom_range(0, lqm_pkg::NUM_QUEUES - 1));
    for (int k = 0; k < lqm_pkg::NUM_ELEMENTS; k++) order[k] = k;
    for (int k = lqm_pkg::NUM_ELEMENTS - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < lqm_pkg::NUM_ELEMENTS; k++) begin
      send_op(lqm_pkg::ACT_APPEND, q, lqm_pkg::ELEM_W'(order[k]));
      // occasional refused re-append from any queue
      if ($urandom_range(0, 7) == 0)
        send_op(lqm_pkg::ACT_APPEND,
                lqm_pkg::QUEUE_W'($urandom_range(0, lqm_pkg::NUM_QUEUES - 1)),
                lqm_pkg::ELEM_W'(order[$urandom_range(0, k)]));
    end
    for (int k = lqm_pkg::NUM_ELEMENTS - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < lqm_pkg::NUM_ELEMENTS; k++) begin
      send_op(lqm_pkg::ACT_REMOVE, q, lqm_pkg::ELEM_W'(order[k]));
      if ($urandom_range(0, 7) == 0)
        send_op(lqm_pkg::ACT_REMOVE,
                lqm_pkg::QUEUE_W'($urandom_range(0, lqm_pkg::NUM_QUEUES - 1)),
                lqm_pkg::ELEM_W'($urandom_range(0, lqm_pkg::NUM_ELEMENTS - 1)));
    end
  endtask

  // mostly legal appends and removes on random queues, some unconstrained commands
  task automatic test_random_traffic(int n_ops);
    int mode;
    int total;
    logic [lqm_pkg::QUEUE_W-1:0] q;
    logic [lqm_pkg::ELEM_W-1:0] cand [$];
    for (int i = 0; i < n_ops; i++) begin
      mode = $urandom_range(0, 99);
      q = lqm_pkg::QUEUE_W'($urandom_range(0, lqm_pkg::NUM_QUEUES - 1));
      total = 0;
      for (int k = 0; k < lqm_pkg::NUM_QUEUES; k++) total += count_of[k];
      cand.delete();
      if (mode < 12) begin
        send_op(1'($urandom_range(0, 1)), q,
                lqm_pkg::ELEM_W'($urandom_range(0, lqm_pkg::NUM_ELEMENTS - 1)));
      end else if (mode < (total > 20 ? 45 : 62)) begin
        for (int k = 0; k < lqm_pkg::NUM_ELEMENTS; k++)
          if (!in_queue[k]) cand.push_back(lqm_pkg::ELEM_W'(k));
        if (cand.size() == 0)
          send_op(lqm_pkg::ACT_APPEND, q,
                  lqm_pkg::ELEM_W'($urandom_range(0, lqm_pkg::NUM_ELEMENTS - 1)));
        else
          send_op(lqm_pkg::ACT_APPEND, q, cand[$urandom_range(0, cand.size() - 1)]);
      end else begin
        for (int k = 0; k < lqm_pkg::NUM_ELEMENTS; k++)
          if (in_queue[k] && owner_of[k] == q) cand.push_back(lqm_pkg::ELEM_W'(k));
        if (cand.size() == 0)
          send_op(lqm_pkg::ACT_REMOVE, q,
                  lqm_pkg::ELEM_W'($urandom_range(0, lqm_pkg::NUM_ELEMENTS - 1)));
        else
          send_op(lqm_pkg::ACT_REMOVE, q, cand[$urandom_range(0, cand.size() - 1)]);
      end
    end
  endtask

  // sender stops until the block has answered everything
  task automatic test_drain_pause();
    wait_drained(4);
  endtask

  // no idle cycles at all in the closing stretch
  task automatic test_back_to_back();
    idle_enable = 1'b0;
    test_random_traffic(250);
    test_full_queue();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_queue();
    test_full_queue();
    test_random_traffic(650);
    test_drain_pause();
    test_random_traffic(550);
    test_back_to_back();
    wait_drained(10);
    if (mismatch_count == 0) begin
      $display("linked_queue_manager_top_test passed");
    end else begin
      $display("linked_queue_manager_top_test failed");
    end
    $finish;
  end

endmodule
